>>> rtl/tlbpt_pkg.sv
// shared widths and sizes for the tlb and page table translator
package tlbpt_pkg;

    // sizes of the page table, the page and the tlb
    localparam int PAGE_ENTRIES = 256;
    localparam int PAGE_BYTES   = 256;
    localparam int TLB_ENTRIES  = 16;

    // field widths
    localparam int ADDR_W  = 16;
    localparam int FETCH_W = 8;
    localparam int CNT_W   = 32;

    // derived widths
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_W = $clog2(PAGE_ENTRIES);
    localparam int FREE_W = PAGE_W + 1;
    localparam int TLB_IW = $clog2(TLB_ENTRIES);
    localparam int TLB_CW = $clog2(TLB_ENTRIES + 1);

endpackage

>>> rtl/tlbpt_if.sv
// address and result channels of the translator

// logical address channel
interface tlbpt_in_if;
    logic                         valid;
    logic                         ready;
    logic [tlbpt_pkg::ADDR_W-1:0] virt_addr;

    modport source (output valid, output virt_addr, input ready);
    modport sink   (input valid, input virt_addr, output ready);
endinterface

// translation result channel
interface tlbpt_out_if;
    logic                          valid;
    logic                          ready;
    logic [tlbpt_pkg::ADDR_W-1:0]  physical_address;
    logic                          tlb_hit;
    logic                          page_fault;
    logic [tlbpt_pkg::FETCH_W-1:0] fetch_page;
    logic [tlbpt_pkg::CNT_W-1:0]   hit_total;
    logic [tlbpt_pkg::CNT_W-1:0]   fault_total;

    modport source (output valid, output physical_address, output tlb_hit,
                    output page_fault, output fetch_page, output hit_total,
                    output fault_total, input ready);
    modport sink   (input valid, input physical_address, input tlb_hit,
                    input page_fault, input fetch_page, input hit_total,
                    input fault_total, output ready);
endinterface

>>> rtl/tlb_page_table_translator_core.sv
// Translates one logical address at a time: the idle state takes the beat and reads the
// page-to-frame memory, the lookup state compares the page against all valid tlb entries at
// once, picks the frame (tlb, page table, or next free frame on a fault), writes the memory on
// a fault and the tlb on a miss and loads the result register. A new address waits until the
// lookup state is left; a held result stalls the lookup state until it is taken. The tlb keeps
// pages in arrival order and drops the oldest when full. Hit and fault totals saturate. No
// clearing pass is needed after reset: page presence is kept in flip-flops cleared by reset.
module tlb_page_table_translator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlbpt_in_if.sink      i_in,
    tlbpt_out_if.source   o_out
);
    import tlbpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state                   r_state;
    logic [ADDR_W-1:0]        r_addr;
    logic [PAGE_W-1:0]        r_tag [TLB_ENTRIES];
    logic [PAGE_W-1:0]        r_frm [TLB_ENTRIES];
    logic [TLB_CW-1:0]        r_fill;
    logic [PAGE_ENTRIES-1:0]  r_present;
    logic [FREE_W-1:0]        r_free;
    logic [CNT_W-1:0]         r_hit_cnt;
    logic [CNT_W-1:0]         r_fault_cnt;
    logic [PAGE_W-1:0]        r_map [PAGE_ENTRIES];
    logic [PAGE_W-1:0]        r_rd_frame;

    logic                     r_out_valid;
    logic [ADDR_W-1:0]        r_out_phys;
    logic                     r_out_hit;
    logic                     r_out_fault;
    logic [FETCH_W-1:0]       r_out_fetch;

    logic                     in_acc;
    logic [PAGE_W-1:0]        in_page;
    logic [PAGE_W-1:0]        page;
    logic [OFF_W-1:0]         offset;
    logic                     hit;
    logic [PAGE_W-1:0]        hit_frame;
    logic                     present;
    logic                     fault;
    logic [PAGE_W-1:0]        frame;
    logic                     done;
    logic [CNT_W-1:0]         n_hit_cnt;
    logic [CNT_W-1:0]         n_fault_cnt;
    logic [PAGE_W+OFF_W-1:0]  phys_full;

    // input handshake
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign in_page    = PAGE_W'(i_in.virt_addr >> OFF_W);

    // lookup of the held address
    assign page    = PAGE_W'(r_addr >> OFF_W);
    assign offset  = r_addr[OFF_W-1:0];
    assign present = r_present[page];

    // parallel tag compare over valid entries
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            if ((TLB_CW'(k) < r_fill) && (r_tag[k] == page)) begin
                hit       = 1'b1;
                hit_frame = r_frm[k];
            end
        end
    end

    // frame selection and counters
    assign fault     = !hit && !present;
    assign frame     = hit ? hit_frame : (present ? r_rd_frame : r_free[PAGE_W-1:0]);
    assign done      = (r_state == S_LOOK) && (!r_out_valid || o_out.ready);
    assign phys_full = {frame, offset};

    always_comb begin
        n_hit_cnt   = r_hit_cnt;
        n_fault_cnt = r_fault_cnt;
        if (hit && (r_hit_cnt != '1)) begin
            n_hit_cnt = r_hit_cnt + CNT_W'(1);
        end
        if (fault && (r_fault_cnt != '1)) begin
            n_fault_cnt = r_fault_cnt + CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_present   <= '0;
            r_free      <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (done) begin
                r_hit_cnt   <= n_hit_cnt;
                r_fault_cnt <= n_fault_cnt;
                if (fault) begin
                    r_present[page] <= 1'b1;
                    r_free          <= FREE_W'(r_free[PAGE_W-1:0]) + FREE_W'(1);
                end
                if (!hit && (r_fill < TLB_CW'(TLB_ENTRIES))) begin
                    r_fill <= r_fill + TLB_CW'(1);
                end
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // tlb entries, appended while room remains, else shifted out oldest first
    always_ff @(posedge i_clk) begin
        if (done && !hit) begin
            if (r_fill < TLB_CW'(TLB_ENTRIES)) begin
                r_tag[r_fill[TLB_IW-1:0]] <= page;
                r_frm[r_fill[TLB_IW-1:0]] <= frame;
            end else begin
                for (int k = 0; k < TLB_ENTRIES - 1; k++) begin
                    r_tag[k] <= r_tag[k+1];
                    r_frm[k] <= r_frm[k+1];
                end
                r_tag[TLB_ENTRIES-1] <= page;
                r_frm[TLB_ENTRIES-1] <= frame;
            end
        end
    end

    // page to frame memory, read on the accepted beat, written on a fault
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr     <= i_in.virt_addr;
            r_rd_frame <= r_map[in_page];
        end
        if (done && fault) begin
            r_map[page] <= r_free[PAGE_W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_phys  <= ADDR_W'(phys_full);
            r_out_hit   <= hit;
            r_out_fault <= fault;
            r_out_fetch <= fault ? FETCH_W'(page) : '0;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.physical_address = r_out_phys;
    assign o_out.tlb_hit          = r_out_hit;
    assign o_out.page_fault       = r_out_fault;
    assign o_out.fetch_page       = r_out_fetch;
    assign o_out.hit_total        = r_hit_cnt;
    assign o_out.fault_total      = r_fault_cnt;

    // tlb fill never passes its size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= TLB_CW'(TLB_ENTRIES))
        else $error("tlb fill count above size");

    // a result is never both a hit and a fault
    a_hit_xor_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_fault))
        else $error("hit and fault on one result");

    // a fault sets the present bit of its page
    a_fault_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && fault) |=> r_present[$past(page)])
        else $error("faulted page not marked present");

    // a new result only comes out of the lookup cycle
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOOK))
        else $error("result without lookup");

endmodule
